// ===== sv/fzm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fzm_pkg
// Shared types, codes and helpers for the fuzzy string match core.
// ----------------------------------------------------------------------------
package fzm_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int EDW         = 7;   // edit distance port width
  localparam int THR_W       = 7;   // register width
  localparam int PCT_FULL    = 100;
  localparam logic [THR_W-1:0] THR_RST    = 7'd80;
  localparam logic [THR_W-1:0] MINSUB_RST = 7'd5;

  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_COMPARE = 2'd2;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MIN_SUB   = 1'b1;

  typedef struct packed {
    logic load;       // take a load transfer
    logic start;      // take a compare transfer
    logic init_step;  // write one entry of the first row
    logic row_step;   // open a new row
    logic cell_wr;    // compute and write one cell
    logic scan_set;   // prepare the containment scan
    logic scan_mode;  // text reads follow the scan counters
    logic scan_cmp;   // compare one byte pair
    logic finish;     // load the result register and clear the strings
  } fzm_cmd_t;

  typedef struct packed {
    logic init_last;
    logic first_empty;
    logic second_empty;
    logic row_last;
    logic col_last;
    logic scan_skip;
    logic byte_eq;
    logic k_last;
    logic pos_last;
  } fzm_sts_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      to_lower = c + 8'd32;
    end else begin
      to_lower = c;
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/fzm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fzm_ctrl
// Sequencer: load handling, edit distance sweep, containment scan, result.
// ----------------------------------------------------------------------------
module fzm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [1:0]      in_mode_i,
  output logic                 in_ready_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output fzm_pkg::fzm_cmd_t    cmd_o,
  input  wire fzm_pkg::fzm_sts_t sts_i
);
  import fzm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_ROW  = 3'd2;
  localparam logic [2:0] S_CRD  = 3'd3;
  localparam logic [2:0] S_CWR  = 3'd4;
  localparam logic [2:0] S_SSET = 3'd5;
  localparam logic [2:0] S_SRD  = 3'd6;
  localparam logic [2:0] S_SCMP = 3'd7;
  localparam logic [2:0] S_DONE = 3'd0; // never used as a code of its own

  logic [2:0] state_q, state_d;
  logic       done_q, done_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == S_IDLE) && !done_q;

  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.scan_mode = (state_q == S_SRD) || (state_q == S_SCMP) || (state_q == S_SSET);
    case (state_q)
      S_IDLE: begin
        if (done_q) begin
          // wait for the result register to drain
          if (out_free) begin
            cmd_o.finish = 1'b1;
            out_valid_d  = 1'b1;
            done_d       = 1'b0;
          end
        end else if (in_valid_i) begin
          if (in_mode_i == MODE_COMPARE) begin
            cmd_o.start = 1'b1;
            state_d     = S_INIT;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_last) begin
          state_d = sts_i.first_empty ? S_SSET : S_ROW;
        end
      end
      S_ROW: begin
        cmd_o.row_step = 1'b1;
        if (!sts_i.second_empty) begin
          state_d = S_CRD;
        end else if (sts_i.row_last) begin
          state_d = S_SSET;
        end
      end
      S_CRD: begin
        state_d = S_CWR;
      end
      S_CWR: begin
        cmd_o.cell_wr = 1'b1;
        if (!sts_i.col_last) begin
          state_d = S_CRD;
        end else if (sts_i.row_last) begin
          state_d = S_SSET;
        end else begin
          state_d = S_ROW;
        end
      end
      S_SSET: begin
        cmd_o.scan_set = 1'b1;
        if (sts_i.scan_skip) begin
          state_d = S_DONE;
          done_d  = 1'b1;
        end else begin
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        state_d = S_SCMP;
      end
      S_SCMP: begin
        cmd_o.scan_cmp = 1'b1;
        if ((sts_i.byte_eq && sts_i.k_last) || (!sts_i.byte_eq && sts_i.pos_last)) begin
          state_d = S_DONE;
          done_d  = 1'b1;
        end else begin
          state_d = S_SRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fzm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fzm_dp
// Datapath: string memories, distance row memory, counters and result.
// ----------------------------------------------------------------------------
module fzm_dp #(
  parameter int MAX_LEN = fzm_pkg::MAX_LEN_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [1:0]              in_mode_i,
  input  wire logic [7:0]              in_char_byte_i,
  input  wire logic                    in_allow_substring_i,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [fzm_pkg::THR_W-1:0] cfg_data_i,
  input  wire fzm_pkg::fzm_cmd_t       cmd_i,
  output fzm_pkg::fzm_sts_t            sts_o,
  output logic                         out_is_match_o,
  output logic [fzm_pkg::EDW-1:0]      out_edit_distance_o,
  output logic                         out_ratio_passed_o,
  output logic                         out_substring_found_o,
  output logic                         out_truncated_o
);
  import fzm_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW    = (LEN_W > THR_W) ? LEN_W : THR_W;
  localparam int PW    = LEN_W + THR_W;

  logic [7:0]       text_a [MAX_LEN];
  logic [7:0]       text_b [MAX_LEN];
  logic [LEN_W-1:0] row_mem [MAX_LEN+1];

  logic [THR_W-1:0] thr_q, minsub_q;
  logic [LEN_W-1:0] len_a_q, len_b_q;
  logic             ovf_q;
  logic [LEN_W-1:0] i_q, j_q, pos_q, k_q;
  logic [LEN_W-1:0] diag_q, left_q, dist_q;
  logic             allow_q, found_q, swap_q;
  logic [7:0]       rd_a_q, rd_b_q;
  logic [LEN_W-1:0] rd_row_q;

  logic             we_a, we_b;
  logic [7:0]       wd_txt;
  logic [IDX_W-1:0] ra_a, ra_b;
  logic             row_we;
  logic [LEN_W-1:0] row_wa, row_wd;
  logic [LEN_W:0]   c_up, c_left, c_sub, c_best;
  logic [LEN_W-1:0] hay_len, ndl_len, maxl, min_len;
  logic             floor_ok;
  logic [PW-1:0]    lhs, rhs;
  logic             ratio;

  assign wd_txt = to_lower(in_char_byte_i);
  assign we_a   = cmd_i.load && (in_mode_i == MODE_LOAD_A) && (len_a_q < LEN_W'(MAX_LEN));
  assign we_b   = cmd_i.load && (in_mode_i == MODE_LOAD_B) && (len_b_q < LEN_W'(MAX_LEN));

  // text read addresses: row byte and column byte, or hay and needle in the scan
  always_comb begin
    if (cmd_i.scan_mode) begin
      ra_a = swap_q ? IDX_W'(k_q) : IDX_W'(pos_q + k_q);
      ra_b = swap_q ? IDX_W'(pos_q + k_q) : IDX_W'(k_q);
    end else begin
      ra_a = IDX_W'(i_q - LEN_W'(1));
      ra_b = IDX_W'(j_q - LEN_W'(1));
    end
  end

  always_comb begin
    c_up   = {1'b0, rd_row_q} + 1'b1;
    c_left = {1'b0, left_q} + 1'b1;
    c_sub  = {1'b0, diag_q} + {{LEN_W{1'b0}}, (rd_a_q != rd_b_q)};
    c_best = c_up;
    if (c_left < c_best) begin
      c_best = c_left;
    end
    if (c_sub < c_best) begin
      c_best = c_sub;
    end
  end

  always_comb begin
    row_we = 1'b0;
    row_wa = j_q;
    row_wd = j_q;
    if (cmd_i.init_step) begin
      row_we = 1'b1;
    end else if (cmd_i.row_step) begin
      row_we = 1'b1;
      row_wa = '0;
      row_wd = i_q;
    end else if (cmd_i.cell_wr) begin
      row_we = 1'b1;
      row_wd = LEN_W'(c_best);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      text_a[IDX_W'(len_a_q)] <= wd_txt;
    end
    if (we_b) begin
      text_b[IDX_W'(len_b_q)] <= wd_txt;
    end
    rd_a_q <= text_a[ra_a];
    rd_b_q <= text_b[ra_b];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    rd_row_q <= row_mem[j_q];
  end

  assign hay_len  = swap_q ? len_b_q : len_a_q;
  assign ndl_len  = swap_q ? len_a_q : len_b_q;
  assign maxl     = (len_a_q >= len_b_q) ? len_a_q : len_b_q;
  assign min_len  = (len_b_q > len_a_q) ? len_a_q : len_b_q;
  assign floor_ok = (CW'(len_a_q) >= CW'(minsub_q)) && (CW'(len_b_q) >= CW'(minsub_q));

  assign lhs   = PW'(maxl - dist_q) * PW'(PCT_FULL);
  assign rhs   = PW'(thr_q) * PW'(maxl);
  assign ratio = (maxl == '0) ? (thr_q <= THR_W'(PCT_FULL)) : (lhs >= rhs);

  always_comb begin
    sts_o              = '0;
    sts_o.init_last    = (j_q == len_b_q);
    sts_o.first_empty  = (len_a_q == '0);
    sts_o.second_empty = (len_b_q == '0);
    sts_o.row_last     = (i_q == len_a_q);
    sts_o.col_last     = (j_q == len_b_q);
    sts_o.scan_skip    = !floor_ok || (min_len == '0);
    sts_o.byte_eq      = (rd_a_q == rd_b_q);
    sts_o.k_last       = (k_q == ndl_len - LEN_W'(1));
    sts_o.pos_last     = (pos_q == hay_len - ndl_len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RST;
      minsub_q <= MINSUB_RST;
      len_a_q  <= '0;
      len_b_q  <= '0;
      ovf_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD: thr_q    <= cfg_data_i;
          REG_MIN_SUB:   minsub_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (we_a) begin
        len_a_q <= len_a_q + LEN_W'(1);
      end
      if (we_b) begin
        len_b_q <= len_b_q + LEN_W'(1);
      end
      if (cmd_i.load && !we_a && !we_b &&
          (in_mode_i == MODE_LOAD_A || in_mode_i == MODE_LOAD_B)) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        len_a_q <= '0;
        len_b_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      allow_q <= in_allow_substring_i;
      j_q     <= '0;
      i_q     <= LEN_W'(1);
    end
    if (cmd_i.init_step) begin
      if (j_q == len_b_q) begin
        dist_q <= j_q;
      end else begin
        j_q <= j_q + LEN_W'(1);
      end
    end
    if (cmd_i.row_step) begin
      diag_q <= i_q - LEN_W'(1);
      left_q <= i_q;
      j_q    <= LEN_W'(1);
      if (len_b_q == '0) begin
        dist_q <= i_q;
        i_q    <= i_q + LEN_W'(1);
      end
    end
    if (cmd_i.cell_wr) begin
      left_q <= LEN_W'(c_best);
      diag_q <= rd_row_q;
      if (j_q == len_b_q) begin
        dist_q <= LEN_W'(c_best);
        i_q    <= i_q + LEN_W'(1);
      end else begin
        j_q <= j_q + LEN_W'(1);
      end
    end
    if (cmd_i.scan_set) begin
      // hay is the longer string; equal lengths compare either way round
      swap_q  <= (len_b_q > len_a_q);
      pos_q   <= '0;
      k_q     <= '0;
      found_q <= floor_ok && (min_len == '0);
    end
    if (cmd_i.scan_cmp) begin
      if (sts_o.byte_eq) begin
        if (sts_o.k_last) begin
          found_q <= 1'b1;
        end else begin
          k_q <= k_q + LEN_W'(1);
        end
      end else begin
        pos_q <= pos_q + LEN_W'(1);
        k_q   <= '0;
      end
    end
    if (cmd_i.finish) begin
      out_is_match_o        <= ratio || (allow_q && found_q);
      out_edit_distance_o   <= EDW'(dist_q);
      out_ratio_passed_o    <= ratio;
      out_substring_found_o <= found_q;
      out_truncated_o       <= ovf_q;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fuzzy_string_match_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_string_match_core
// Case-insensitive Levenshtein similarity and containment match of two strings.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | transfer
//  in       | in_valid_i/in_ready_o, mode, byte, allow  | valid & ready
//  out      | out_valid_o/out_ready_i, five results      | valid & ready
//  cfg      | cfg_we_i, cfg_idx_i, cfg_data_i           | we high
//
// A load transfer appends one byte to its string, or flags truncation when the
// string is full. A compare writes the first row, runs the distance sweep over
// one row memory a cell at a time, sets up the containment scan, runs the
// byte-serial scan itself and loads the result register. Reset needs no
// clearing pass. Input is held off while a compare runs or while its result
// waits for the output register.
module fuzzy_string_match_core #(
  parameter int MAX_LEN = fzm_pkg::MAX_LEN_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                in_mode_i,
  input  wire logic [7:0]                in_char_byte_i,
  input  wire logic                      in_allow_substring_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           out_is_match_o,
  output logic [fzm_pkg::EDW-1:0]        out_edit_distance_o,
  output logic                           out_ratio_passed_o,
  output logic                           out_substring_found_o,
  output logic                           out_truncated_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [fzm_pkg::THR_W-1:0] cfg_data_i
);
  import fzm_pkg::*;

  fzm_cmd_t cmd;
  fzm_sts_t sts;

  fzm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_mode_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  fzm_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_mode_i             (in_mode_i),
    .in_char_byte_i        (in_char_byte_i),
    .in_allow_substring_i  (in_allow_substring_i),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .out_is_match_o        (out_is_match_o),
    .out_edit_distance_o   (out_edit_distance_o),
    .out_ratio_passed_o    (out_ratio_passed_o),
    .out_substring_found_o (out_substring_found_o),
    .out_truncated_o       (out_truncated_o)
  );

endmodule
`default_nettype wire
